// ----- hdl/kfli_pkg.sv -----
// ============================================================================
// kfli_pkg: shared types and constants of the daily keyframe light interpolator
// Field widths, fixed-point constants, register and action codes, the table
// entry layout and the state encodings of the top level and the channel lanes.
// ============================================================================
package kfli_pkg;

    // Field widths
    localparam int TIME_W    = 17;
    localparam int LVL_W     = 14;
    localparam int OUT_W     = 13;
    localparam int FAN_W     = 14;
    localparam int SCALE_W   = 17;
    localparam int INDEX_W   = 4;
    localparam int COUNT_W   = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 5;
    localparam int CHANNELS  = 3;

    // Signed width that holds every elapsed time and span, wrap included
    localparam int SPAN_W  = 20;
    // Unsigned width of a span once it is known to be positive
    localparam int E_W     = 18;
    localparam int SUM_W   = 15;
    localparam int QUOT_W  = 12;

    // Constants of the light curve
    localparam int unsigned DAY_SECONDS       = 86400;
    localparam int unsigned LEVEL_CAP         = 6000;
    localparam int unsigned FAN_FLOOR         = 4000;
    localparam int unsigned FAN_SUM_THRESHOLD = 1500;
    localparam int unsigned Q16_ONE           = 65536;
    localparam int unsigned ROUND_HALF        = 32768;
    localparam int unsigned Q16_SHIFT         = 16;
    // x / 10 equals (x * 52429) >> 19 for every 16-bit x
    localparam int unsigned DIV10_RECIP       = 52429;
    localparam int unsigned DIV10_SHIFT       = 19;

    // Channel order inside a level vector
    localparam int CH_BLUE  = 0;
    localparam int CH_WHITE = 1;
    localparam int CH_UV    = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEYFRAME_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN_OVERRIDE   = 1'b1;

    // Input word actions
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    typedef logic [CHANNELS-1:0][LVL_W-1:0] t_lv;

    typedef struct packed {
        logic [TIME_W-1:0] t;
        t_lv               lv;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Command from the sequencer to one channel lane
    typedef struct packed {
        logic               start;
        logic               interp;
        logic [LVL_W-1:0]   base;
        logic [LVL_W-1:0]   other;
        logic [E_W-1:0]     e;
        logic [E_W-1:0]     dt;
        logic [SCALE_W-1:0] scale;
    } t_lane_cmd;

    // Response of one channel lane
    typedef struct packed {
        logic             done;
        logic [OUT_W-1:0] level;
    } t_lane_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SELECT,
        ST_CLAMP,
        ST_LANES,
        ST_SUM,
        ST_FAN,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        LS_IDLE,
        LS_MUL_D,
        LS_ROUND,
        LS_DIV,
        LS_FIX,
        LS_MUL_S,
        LS_CAP
    } t_lane_state;

endpackage

// ----- hdl/kfli_in_if.sv -----
// ============================================================================
// kfli_in_if: input channel of the keyframe light interpolator
// Valid/ready channel that carries one load or evaluate word.
// ============================================================================
interface kfli_in_if;
    import kfli_pkg::*;

    logic               valid;
    logic               ready;
    logic               action;
    logic [INDEX_W-1:0] entry_index;
    logic [TIME_W-1:0]  entry_time;
    logic [LVL_W-1:0]   entry_blue;
    logic [LVL_W-1:0]   entry_white;
    logic [LVL_W-1:0]   entry_uv;
    logic [TIME_W-1:0]  second_of_day;
    logic [SCALE_W-1:0] accl_scale;

    modport source (
        output valid, action, entry_index, entry_time, entry_blue, entry_white,
               entry_uv, second_of_day, accl_scale,
        input  ready
    );

    modport sink (
        input  valid, action, entry_index, entry_time, entry_blue, entry_white,
               entry_uv, second_of_day, accl_scale,
        output ready
    );

endinterface

// ----- hdl/kfli_out_if.sv -----
// ============================================================================
// kfli_out_if: result channel of the keyframe light interpolator
// Valid/ready channel that carries the three light levels and the fan level.
// ============================================================================
interface kfli_out_if;
    import kfli_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] level_blue;
    logic [OUT_W-1:0] level_white;
    logic [OUT_W-1:0] level_uv;
    logic [FAN_W-1:0] fan_level;
    logic             fan_valid;

    modport source (
        output valid, level_blue, level_white, level_uv, fan_level, fan_valid,
        input  ready
    );

    modport sink (
        input  valid, level_blue, level_white, level_uv, fan_level, fan_valid,
        output ready
    );

endinterface

// ----- hdl/daily_keyframe_light_interpolator_core.sv -----
// ============================================================================
// daily_keyframe_light_interpolator_core: daily lighting keyframe interpolator
// Operation: a load word is written to the table as it is taken. An evaluate
//   word scans the table (one RAM read per cycle), then runs the bit-serial
//   multiply, divide and scale in each channel lane when it blends two
//   keyframes, and only the bit-serial scale when it holds one.
// Throughput: one evaluate word at a time; the next word is taken while a
//   finished result still waits in the output register.
// Reset: clears control state and both configuration registers; the keyframe
//   table is undefined until loaded and gets no clearing pass.
// ============================================================================
module daily_keyframe_light_interpolator_core #(
    parameter int MAX_KEYFRAMES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [kfli_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kfli_pkg::CFG_DAT_W-1:0] i_cfg_data,
    kfli_in_if.sink                        i_in,
    kfli_out_if.source                     o_out
);
    import kfli_pkg::*;

    localparam int AW = $clog2(MAX_KEYFRAMES);
    localparam int CW = $clog2(MAX_KEYFRAMES + 1);

    t_state                     r_state, n_state;
    logic [COUNT_W-1:0]         r_kf_count, n_kf_count;
    logic                       r_fan_ovr, n_fan_ovr;
    logic [TIME_W-1:0]          r_s, n_s;
    logic [SCALE_W-1:0]         r_scale, n_scale;
    logic [CW-1:0]              r_n, n_n;
    logic [CW-1:0]              r_rd_addr, n_rd_addr;
    logic                       r_rd_pend, n_rd_pend;
    logic [CW-1:0]              r_rd_idx, n_rd_idx;
    t_entry                     r_first, n_first;
    t_entry                     r_last, n_last;
    t_entry                     r_lo, n_lo;
    t_entry                     r_hi, n_hi;
    logic [CW-1:0]              r_lo_idx, n_lo_idx;
    logic [CW-1:0]              r_hi_idx, n_hi_idx;
    logic                       r_lo_found, n_lo_found;
    logic                       r_hi_found, n_hi_found;
    t_lv                        r_k1, n_k1;
    t_lv                        r_k2, n_k2;
    logic signed [SPAN_W-1:0]   r_e, n_e;
    logic signed [SPAN_W-1:0]   r_dt, n_dt;
    logic                       r_blend, n_blend;
    logic [CHANNELS-1:0][OUT_W-1:0] r_lvl, n_lvl;
    logic [SUM_W-1:0]           r_sum, n_sum;
    logic [QUOT_W-1:0]          r_fan_q, n_fan_q;
    logic                       r_out_valid, n_out_valid;
    logic [CHANNELS-1:0][OUT_W-1:0] r_out_lvl, n_out_lvl;
    logic [FAN_W-1:0]           r_out_fan, n_out_fan;
    logic                       r_out_fan_valid, n_out_fan_valid;

    logic                       in_acc;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    t_entry                     ram_wdata;
    logic [ENTRY_W-1:0]         ram_rdata;
    t_entry                     rd_entry;
    logic [CW-1:0]              n_eff;
    t_lane_cmd [CHANNELS-1:0]   lane_cmd;
    t_lane_rsp [CHANNELS-1:0]   lane_rsp;
    logic                       lanes_done;
    logic                       hold;
    logic                       take_k2;
    logic signed [SPAN_W-1:0]   wrap_base;
    logic [SUM_W:0]             fan_x;
    logic [2*(SUM_W+1)-1:0]     fan_prod;
    logic [FAN_W-1:0]           fan_val;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign rd_entry   = t_entry'(ram_rdata);

    // Keyframe table
    kfli_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_KEYFRAMES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // One serial lane per light channel
    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        kfli_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (lane_cmd[c]),
            .o_rsp   (lane_rsp[c])
        );
    end

    // Span and clamp decisions shared by all channels
    always_comb begin
        hold    = !r_blend || (r_dt <= 0) || (r_e <= 0);
        take_k2 = !hold && (r_e >= r_dt);
        lanes_done = 1'b1;
        for (int c = 0; c < CHANNELS; c++) begin
            lane_cmd[c].start  = (r_state == ST_CLAMP);
            lane_cmd[c].interp = !hold && !take_k2;
            lane_cmd[c].base   = take_k2 ? r_k2[c] : r_k1[c];
            lane_cmd[c].other  = r_k2[c];
            lane_cmd[c].e      = r_e[E_W-1:0];
            lane_cmd[c].dt     = r_dt[E_W-1:0];
            lane_cmd[c].scale  = r_scale;
            lanes_done         = lanes_done && lane_rsp[c].done;
        end
    end

    // Main sequencer
    always_comb begin
        n_state         = r_state;
        n_kf_count      = r_kf_count;
        n_fan_ovr       = r_fan_ovr;
        n_s             = r_s;
        n_scale         = r_scale;
        n_n             = r_n;
        n_rd_addr       = r_rd_addr;
        n_rd_pend       = r_rd_pend;
        n_rd_idx        = r_rd_idx;
        n_first         = r_first;
        n_last          = r_last;
        n_lo            = r_lo;
        n_hi            = r_hi;
        n_lo_idx        = r_lo_idx;
        n_hi_idx        = r_hi_idx;
        n_lo_found      = r_lo_found;
        n_hi_found      = r_hi_found;
        n_k1            = r_k1;
        n_k2            = r_k2;
        n_e             = r_e;
        n_dt            = r_dt;
        n_blend         = r_blend;
        n_lvl           = r_lvl;
        n_sum           = r_sum;
        n_fan_q         = r_fan_q;
        n_out_valid     = r_out_valid;
        n_out_lvl       = r_out_lvl;
        n_out_fan       = r_out_fan;
        n_out_fan_valid = r_out_fan_valid;

        ram_we    = 1'b0;
        ram_waddr = AW'(i_in.entry_index);
        ram_wdata.t             = i_in.entry_time;
        ram_wdata.lv[CH_BLUE]   = i_in.entry_blue;
        ram_wdata.lv[CH_WHITE]  = i_in.entry_white;
        ram_wdata.lv[CH_UV]     = i_in.entry_uv;

        // Keyframe count, saturated at the table depth
        n_eff = (32'(r_kf_count) > MAX_KEYFRAMES) ? CW'(MAX_KEYFRAMES) : CW'(r_kf_count);

        wrap_base = SPAN_W'(DAY_SECONDS) - $signed({3'b000, r_last.t});
        fan_x     = {r_sum, 1'b0} + (SUM_W+1)'(5);
        fan_prod  = (2*(SUM_W+1))'(fan_x) * (2*(SUM_W+1))'(DIV10_RECIP);
        fan_val   = (32'(r_sum) > FAN_SUM_THRESHOLD) ? (FAN_W'(FAN_FLOOR) + FAN_W'(r_fan_q))
                                                    : FAN_W'(FAN_FLOOR);

        // Result word leaves the output register
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        // Configuration writes
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEYFRAME_COUNT: n_kf_count = i_cfg_data;
                CFG_FAN_OVERRIDE:   n_fan_ovr  = i_cfg_data[0];
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.action == ACT_LOAD) begin
                        ram_we = (32'(i_in.entry_index) < MAX_KEYFRAMES);
                    end else begin
                        n_s        = i_in.second_of_day;
                        n_scale    = (32'(i_in.accl_scale) > Q16_ONE) ? SCALE_W'(Q16_ONE)
                                                                      : i_in.accl_scale;
                        n_n        = n_eff;
                        n_rd_addr  = '0;
                        n_rd_pend  = 1'b0;
                        n_lo_found = 1'b0;
                        n_hi_found = 1'b0;
                        n_state    = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // Issue one read per cycle
                if (r_rd_addr != r_n) begin
                    n_rd_addr = r_rd_addr + 1'b1;
                    n_rd_pend = 1'b1;
                    n_rd_idx  = r_rd_addr;
                end else begin
                    n_rd_pend = 1'b0;
                end
                // Track first, last and the bounding keyframes as entries return
                if (r_rd_pend) begin
                    if (r_rd_idx == '0) begin
                        n_first = rd_entry;
                    end
                    if (r_rd_idx == r_n - CW'(1)) begin
                        n_last = rd_entry;
                    end
                    if (rd_entry.t <= r_s) begin
                        n_lo       = rd_entry;
                        n_lo_idx   = r_rd_idx;
                        n_lo_found = 1'b1;
                    end
                    if (rd_entry.t >= r_s && !r_hi_found) begin
                        n_hi       = rd_entry;
                        n_hi_idx   = r_rd_idx;
                        n_hi_found = 1'b1;
                    end
                end
                if (r_rd_addr == r_n && !r_rd_pend) begin
                    n_state = ST_SELECT;
                end
            end
            ST_SELECT: begin
                // Pick the pair to blend and form elapsed time and span
                n_k2    = r_first.lv;
                n_dt    = wrap_base + $signed({3'b000, r_first.t});
                n_e     = $signed({3'b000, r_s}) - $signed({3'b000, r_last.t});
                n_blend = 1'b1;
                n_k1    = r_last.lv;
                priority if (r_n == '0) begin
                    n_k1    = '0;
                    n_blend = 1'b0;
                end else if (r_n == CW'(1)) begin
                    n_k1    = r_first.lv;
                    n_blend = 1'b0;
                end else if (!r_lo_found) begin
                    // Before the first keyframe: wrap back from the last one
                    n_e = wrap_base + $signed({3'b000, r_s});
                end else if (!r_hi_found || r_lo_idx == r_n - CW'(1)) begin
                    // After the last keyframe: wrap forward to the first one
                end else if (r_lo_idx == r_hi_idx) begin
                    n_k1    = r_lo.lv;
                    n_blend = 1'b0;
                end else begin
                    n_k1 = r_lo.lv;
                    n_k2 = r_hi.lv;
                    n_dt = $signed({3'b000, r_hi.t}) - $signed({3'b000, r_lo.t});
                    n_e  = $signed({3'b000, r_s}) - $signed({3'b000, r_lo.t});
                end
                n_state = ST_CLAMP;
            end
            ST_CLAMP: begin
                n_state = ST_LANES;
            end
            ST_LANES: begin
                if (lanes_done) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        n_lvl[c] = lane_rsp[c].level;
                    end
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                n_sum   = SUM_W'(r_lvl[CH_BLUE]) + SUM_W'(r_lvl[CH_WHITE])
                        + SUM_W'(r_lvl[CH_UV]);
                n_state = ST_FAN;
            end
            ST_FAN: begin
                // Rounded sum / 5 through a reciprocal multiply; never above the ceiling
                n_fan_q = fan_prod[DIV10_SHIFT +: QUOT_W];
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid     = 1'b1;
                    n_out_lvl       = r_lvl;
                    n_out_fan       = r_fan_ovr ? '0 : fan_val;
                    n_out_fan_valid = !r_fan_ovr;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_kf_count  <= '0;
            r_fan_ovr   <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kf_count  <= n_kf_count;
            r_fan_ovr   <= n_fan_ovr;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_s             <= n_s;
        r_scale         <= n_scale;
        r_n             <= n_n;
        r_rd_addr       <= n_rd_addr;
        r_rd_idx        <= n_rd_idx;
        r_first         <= n_first;
        r_last          <= n_last;
        r_lo            <= n_lo;
        r_hi            <= n_hi;
        r_lo_idx        <= n_lo_idx;
        r_hi_idx        <= n_hi_idx;
        r_lo_found      <= n_lo_found;
        r_hi_found      <= n_hi_found;
        r_k1            <= n_k1;
        r_k2            <= n_k2;
        r_e             <= n_e;
        r_dt            <= n_dt;
        r_blend         <= n_blend;
        r_lvl           <= n_lvl;
        r_sum           <= n_sum;
        r_fan_q         <= n_fan_q;
        r_out_lvl       <= n_out_lvl;
        r_out_fan       <= n_out_fan;
        r_out_fan_valid <= n_out_fan_valid;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.level_blue  = r_out_lvl[CH_BLUE];
    assign o_out.level_white = r_out_lvl[CH_WHITE];
    assign o_out.level_uv    = r_out_lvl[CH_UV];
    assign o_out.fan_level   = r_out_fan;
    assign o_out.fan_valid   = r_out_fan_valid;

    // Lanes only report while the sequencer waits for them
    a_lanes_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lanes_done |-> r_state == ST_LANES)
        else $error("lane result outside the wait state");

    // Table writes come only from a load word taken in idle
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_IDLE && i_in.valid && i_in.action == ACT_LOAD))
        else $error("table write outside a load word");

    // No table read is in flight once the scan has finished
    a_scan_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !r_rd_pend)
        else $error("scan read pending in idle");

    // A finished evaluation always lands in the output register
    a_done_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && (!r_out_valid || o_out.ready)) |=> r_out_valid)
        else $error("result word lost");

    // Levels respect the cap and the fan level is zero when not produced
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (32'(o_out.level_blue) <= LEVEL_CAP
                         && 32'(o_out.level_white) <= LEVEL_CAP
                         && 32'(o_out.level_uv) <= LEVEL_CAP
                         && (o_out.fan_valid || o_out.fan_level == '0)))
        else $error("result word out of range");

endmodule

// ----- hdl/kfli_ram.sv -----
// ============================================================================
// kfli_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ============================================================================
module kfli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/kfli_lane.sv -----
// ============================================================================
// kfli_lane: bit-serial interpolate, scale and cap for one light channel
// Shift-add multiply of the level step by the elapsed time, restoring divide
// by the span with rounding, then shift-add multiply by the Q16 scale.
// ============================================================================
module kfli_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kfli_pkg::t_lane_cmd i_cmd,
    output kfli_pkg::t_lane_rsp o_rsp
);
    import kfli_pkg::*;

    // Product register: multiplicand-wide upper half, multiplier-wide lower half
    localparam int MC_W  = E_W;
    localparam int P_W   = MC_W + SCALE_W;
    localparam int NUM_W = E_W + LVL_W + 1;
    localparam int REM_W = E_W + 1;
    localparam int RND_W = LVL_W + SCALE_W;
    localparam int CNT_W = $clog2(SCALE_W);

    t_lane_state        r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [P_W-1:0]     r_p, n_p;
    logic [MC_W-1:0]    r_mcand, n_mcand;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [LVL_W-1:0]   r_qs, n_qs;
    logic [E_W-1:0]     r_dt, n_dt;
    logic [LVL_W-1:0]   r_a, n_a;
    logic               r_flip, n_flip;
    logic [SCALE_W-1:0] r_scale, n_scale;
    logic [OUT_W-1:0]   r_level, n_level;
    logic               r_done, n_done;

    logic [MC_W:0]      mul_sum;
    logic [LVL_W-1:0]   diff;
    logic [NUM_W-1:0]   num;
    logic [REM_W-1:0]   trial;
    logic               ge;
    logic [LVL_W-1:0]   lvl;
    logic [RND_W-1:0]   rnd;
    logic [RND_W-Q16_SHIFT-1:0] scaled;

    // Sequencer and serial datapath
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_p     = r_p;
        n_mcand = r_mcand;
        n_rem   = r_rem;
        n_qs    = r_qs;
        n_dt    = r_dt;
        n_a     = r_a;
        n_flip  = r_flip;
        n_scale = r_scale;
        n_level = r_level;
        n_done  = 1'b0;

        // One shift-add step: add the multiplicand when the multiplier bit is set
        mul_sum = {1'b0, r_p[P_W-1:SCALE_W]} + (r_p[0] ? {1'b0, r_mcand} : '0);
        diff    = (i_cmd.other < i_cmd.base) ? (i_cmd.base - i_cmd.other)
                                             : (i_cmd.other - i_cmd.base);
        num     = r_p[NUM_W-1:0] + NUM_W'(r_dt[E_W-1:1]);
        trial   = {r_rem[E_W-1:0], r_qs[LVL_W-1]};
        ge      = (trial >= {1'b0, r_dt});
        lvl     = r_flip ? (r_a - r_qs) : (r_a + r_qs);
        rnd     = r_p[RND_W-1:0] + RND_W'(ROUND_HALF);
        scaled  = rnd[RND_W-1:Q16_SHIFT];

        unique case (r_state)
            LS_IDLE: begin
                if (i_cmd.start) begin
                    n_a     = i_cmd.base;
                    n_scale = i_cmd.scale;
                    n_cnt   = '0;
                    if (i_cmd.interp) begin
                        n_flip  = (i_cmd.other < i_cmd.base);
                        n_p     = {MC_W'(0), SCALE_W'(diff)};
                        n_mcand = i_cmd.e;
                        n_dt    = i_cmd.dt;
                        n_state = LS_MUL_D;
                    end else begin
                        n_p     = {MC_W'(0), i_cmd.scale};
                        n_mcand = MC_W'(i_cmd.base);
                        n_state = LS_MUL_S;
                    end
                end
            end
            LS_MUL_D: begin
                n_p   = {mul_sum, r_p[SCALE_W-1:1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SCALE_W - 1)) begin
                    n_state = LS_ROUND;
                end
            end
            LS_ROUND: begin
                // Add half the span for round to nearest, then split for the divide
                n_rem   = num[NUM_W-1:LVL_W];
                n_qs    = num[LVL_W-1:0];
                n_cnt   = '0;
                n_state = LS_DIV;
            end
            LS_DIV: begin
                n_rem = ge ? (trial - {1'b0, r_dt}) : trial;
                n_qs  = {r_qs[LVL_W-2:0], ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(LVL_W - 1)) begin
                    n_state = LS_FIX;
                end
            end
            LS_FIX: begin
                n_p     = {MC_W'(0), r_scale};
                n_mcand = MC_W'(lvl);
                n_cnt   = '0;
                n_state = LS_MUL_S;
            end
            LS_MUL_S: begin
                n_p   = {mul_sum, r_p[SCALE_W-1:1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SCALE_W - 1)) begin
                    n_state = LS_CAP;
                end
            end
            LS_CAP: begin
                n_level = (32'(scaled) > LEVEL_CAP) ? OUT_W'(LEVEL_CAP) : scaled[OUT_W-1:0];
                n_done  = 1'b1;
                n_state = LS_IDLE;
            end
            default: begin
                n_state = LS_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_p     <= n_p;
        r_mcand <= n_mcand;
        r_rem   <= n_rem;
        r_qs    <= n_qs;
        r_dt    <= n_dt;
        r_a     <= n_a;
        r_flip  <= n_flip;
        r_scale <= n_scale;
        r_level <= n_level;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.level = r_level;

    // A command only arrives while the lane is free
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> r_state == LS_IDLE)
        else $error("lane started while busy");

    // The divide quotient never exceeds the level step, so the remainder stays below the span
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == LS_DIV |-> r_rem < {1'b0, r_dt})
        else $error("divide remainder out of range");

    // The result is announced in the cycle after the cap state
    a_done_after_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == LS_CAP |=> r_done)
        else $error("lane result lost");

endmodule

// ----- test/daily_keyframe_light_interpolator_core_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// daily_keyframe_light_interpolator_core_checker: light level scoreboard
// Watches the configuration port and both channels of the interpolator. It
// keeps its own keyframe table and register copies, works out the expected
// light and fan levels of every accepted evaluate word, and compares each
// accepted result word with the oldest expected one.
// ============================================================================
module daily_keyframe_light_interpolator_core_checker #(
    parameter int MAX_KEYFRAMES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [kfli_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kfli_pkg::CFG_DAT_W-1:0] i_cfg_data,
    kfli_in_if                             i_in,
    kfli_out_if                            i_out,
    output int                             o_fail_count,
    output int                             o_pending
);
    import kfli_pkg::*;

    localparam int unsigned FAN_CEIL = 10000;

    typedef struct packed {
        logic [OUT_W-1:0] blue;
        logic [OUT_W-1:0] white;
        logic [OUT_W-1:0] uv;
        logic [FAN_W-1:0] fan;
        logic             fan_valid;
    } t_light_word;

    // Predicted copy of the table and of the registers.
    logic [TIME_W-1:0]  kf_time  [MAX_KEYFRAMES];
    logic [LVL_W-1:0]   kf_level [MAX_KEYFRAMES][CHANNELS];
    logic [COUNT_W-1:0] kf_count;
    logic               fan_off;

    t_light_word expected_lights [$];
    int          mismatches;

    // Linear blend of one channel, delta rounded half away from zero.
    function automatic int unsigned blend_level(int unsigned a, int unsigned b,
                                                longint e, longint dt);
        longint unsigned d;
        longint unsigned q;
        if (dt <= 0 || e <= 0) return a;
        if (e >= dt) return b;
        d = (b >= a) ? longint'(b - a) : longint'(a - b);
        q = (d * longint'(e) + longint'(dt) / 2) / longint'(dt);
        return (b >= a) ? a + int'(q) : a - int'(q);
    endfunction

    // Expected result word for an evaluate at one second of day.
    function automatic t_light_word predict_lights(logic [TIME_W-1:0] sod,
                                                   logic [SCALE_W-1:0] scale_in);
        int unsigned     n;
        int unsigned     lv [CHANNELS];
        int unsigned     sum;
        int unsigned     fan;
        int unsigned     sc;
        longint unsigned v;
        longint          s, lo, hi, dt, e, t, tf, tl;
        int              ia, ib;
        t_light_word     r;

        n = (kf_count > MAX_KEYFRAMES) ? MAX_KEYFRAMES : kf_count;
        s = longint'(sod);
        if (n == 0) begin
            for (int c = 0; c < CHANNELS; c++) lv[c] = 0;
        end else if (n == 1) begin
            for (int c = 0; c < CHANNELS; c++) lv[c] = kf_level[0][c];
        end else begin
            lo = -1;
            hi = -1;
            for (int i = 0; i < n; i++) begin
                t = longint'(kf_time[i]);
                if (t <= s) lo = i;
                if (t >= s && hi < 0) hi = i;
            end
            tf = longint'(kf_time[0]);
            tl = longint'(kf_time[n-1]);
            if (lo < 0) begin
                // Before the first keyframe: blend from the last across midnight.
                dt = (longint'(DAY_SECONDS) - tl) + tf;
                e  = (longint'(DAY_SECONDS) - tl) + s;
                ia = n - 1;
                ib = 0;
            end else if (hi < 0 || lo == n - 1) begin
                // After the last keyframe: blend toward the first of the next day.
                dt = (longint'(DAY_SECONDS) - tl) + tf;
                e  = s - tl;
                ia = n - 1;
                ib = 0;
            end else if (lo == hi) begin
                // Exactly on a keyframe: its levels are held.
                dt = 0;
                e  = 0;
                ia = lo;
                ib = lo;
            end else begin
                dt = longint'(kf_time[hi]) - longint'(kf_time[lo]);
                e  = s - longint'(kf_time[lo]);
                ia = lo;
                ib = hi;
            end
            for (int c = 0; c < CHANNELS; c++) begin
                lv[c] = blend_level(kf_level[ia][c], kf_level[ib][c], e, dt);
            end
        end

        // Acclimation scale, saturated at one, then the cap.
        sc  = (scale_in > Q16_ONE) ? Q16_ONE : scale_in;
        sum = 0;
        for (int c = 0; c < CHANNELS; c++) begin
            v = (longint'(lv[c]) * sc + ROUND_HALF) >> Q16_SHIFT;
            if (v > LEVEL_CAP) v = LEVEL_CAP;
            lv[c] = int'(v);
            sum += lv[c];
        end
        r.blue  = lv[CH_BLUE][OUT_W-1:0];
        r.white = lv[CH_WHITE][OUT_W-1:0];
        r.uv    = lv[CH_UV][OUT_W-1:0];

        // Fan curve from the sum of the capped levels.
        if (fan_off) begin
            r.fan       = '0;
            r.fan_valid = 1'b0;
        end else begin
            if (sum > FAN_SUM_THRESHOLD) begin
                fan = FAN_FLOOR + (2 * sum + 5) / 10;
                if (fan > FAN_CEIL) fan = FAN_CEIL;
            end else begin
                fan = FAN_FLOOR;
            end
            r.fan       = fan[FAN_W-1:0];
            r.fan_valid = 1'b1;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Track registers and words at every clock edge.
    always @(posedge i_clk) begin : watch
        t_light_word want;
        if (!i_rst_n) begin
            kf_count   = '0;
            fan_off    = 1'b0;
            mismatches = 0;
            for (int i = 0; i < MAX_KEYFRAMES; i++) begin
                kf_time[i] = '0;
                for (int c = 0; c < CHANNELS; c++) kf_level[i][c] = '0;
            end
            expected_lights.delete();
        end else begin
            // Results first, so a word of this edge never meets its own expectation.
            if (i_out.valid && i_out.ready) begin
                if (expected_lights.size() == 0) begin
                    $error("result word arrived with no evaluate pending");
                    mismatches++;
                end else begin
                    want = expected_lights.pop_front();
                    check_field("level_blue", want.blue, i_out.level_blue);
                    check_field("level_white", want.white, i_out.level_white);
                    check_field("level_uv", want.uv, i_out.level_uv);
                    check_field("fan_level", want.fan, i_out.fan_level);
                    check_field("fan_valid", want.fan_valid, i_out.fan_valid);
                end
            end

            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_KEYFRAME_COUNT) kf_count = i_cfg_data;
                else if (i_cfg_idx == CFG_FAN_OVERRIDE) fan_off = i_cfg_data[0];
            end

            if (i_in.valid && i_in.ready) begin
                if (i_in.action == ACT_LOAD) begin
                    if (i_in.entry_index < MAX_KEYFRAMES) begin
                        kf_time[i_in.entry_index]            = i_in.entry_time;
                        kf_level[i_in.entry_index][CH_BLUE]  = i_in.entry_blue;
                        kf_level[i_in.entry_index][CH_WHITE] = i_in.entry_white;
                        kf_level[i_in.entry_index][CH_UV]    = i_in.entry_uv;
                    end
                end else begin
                    expected_lights.push_back(
                        predict_lights(i_in.second_of_day, i_in.accl_scale));
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_lights.size();
    end

endmodule

// ----- test/daily_keyframe_light_interpolator_core_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// daily_keyframe_light_interpolator_core_test: top of the interpolator bench
// Drives load and evaluate words and the configuration port, with random
// gaps on the input and random stalls on the result side. A directed opening
// covers empty, single and full tables; random phases then reload the table
// and evaluate under several keyframe counts and fan settings. The checker
// beside the block predicts and compares; this module gives the verdict.
// ============================================================================
module daily_keyframe_light_interpolator_core_test;
    import kfli_pkg::*;

    localparam int GAP_MAX       = 17;
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASES        = 12;
    localparam int PHASE_WORDS   = 70;
    localparam int TABLE_SIZE    = 16;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DAT_W-1:0] cfg_data;
    int                   fail_count;
    int                   pending_lights;
    bit                   no_idle;
    int unsigned          active_keyframes;
    logic [TIME_W-1:0]    loaded_time [TABLE_SIZE];

    kfli_in_if  in_ch ();
    kfli_out_if out_ch ();

    daily_keyframe_light_interpolator_core #(
        .MAX_KEYFRAMES(TABLE_SIZE)
    ) dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in      (in_ch),
        .o_out     (out_ch)
    );

    daily_keyframe_light_interpolator_core_checker #(
        .MAX_KEYFRAMES(TABLE_SIZE)
    ) light_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending_lights)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    function automatic logic [LVL_W-1:0] rand_level();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return LVL_W'(10000);
            2: return LVL_W'($urandom_range(10001, 16383));
            default: return LVL_W'($urandom_range(0, 10000));
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] rand_scale();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return SCALE_W'($urandom_range(Q16_ONE + 1, 131071));
            2, 3, 4, 5: return SCALE_W'(Q16_ONE);
            default: return SCALE_W'($urandom_range(0, Q16_ONE));
        endcase
    endfunction

    // Second of day aimed at the interesting spots of the current table.
    function automatic logic [TIME_W-1:0] pick_second();
        int unsigned k;
        k = (active_keyframes > 0) ? $urandom_range(0, active_keyframes - 1) : 0;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return TIME_W'(DAY_SECONDS - 1);
            2, 3: return loaded_time[k];
            4: return loaded_time[k] + 1'b1;
            5: return TIME_W'($urandom_range(0, loaded_time[0]));
            6: return TIME_W'($urandom_range(DAY_SECONDS, 131071));
            default: return TIME_W'($urandom_range(0, DAY_SECONDS - 1));
        endcase
    endfunction

    // One input word, held until the block takes it.
    task automatic send_word(input logic act, input logic [INDEX_W-1:0] idx,
                             input logic [TIME_W-1:0] t, input logic [LVL_W-1:0] b,
                             input logic [LVL_W-1:0] w, input logic [LVL_W-1:0] u,
                             input logic [TIME_W-1:0] sod,
                             input logic [SCALE_W-1:0] scale);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.action        <= act;
        in_ch.entry_index   <= idx;
        in_ch.entry_time    <= t;
        in_ch.entry_blue    <= b;
        in_ch.entry_white   <= w;
        in_ch.entry_uv      <= u;
        in_ch.second_of_day <= sod;
        in_ch.accl_scale    <= scale;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic send_load(input logic [INDEX_W-1:0] idx, input logic [TIME_W-1:0] t,
                             input logic [LVL_W-1:0] b, input logic [LVL_W-1:0] w,
                             input logic [LVL_W-1:0] u);
        loaded_time[idx] = t;
        send_word(ACT_LOAD, idx, t, b, w, u, TIME_W'($urandom), SCALE_W'($urandom));
    endtask

    task automatic send_eval(input logic [TIME_W-1:0] sod, input logic [SCALE_W-1:0] scale);
        send_word(ACT_EVAL, INDEX_W'($urandom), TIME_W'($urandom), LVL_W'($urandom),
                  LVL_W'($urandom), LVL_W'($urandom), sod, scale);
    endtask

    // Wait until every result is in and the block has gone quiet.
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_lights != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input int unsigned count, input bit override);
        settle();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_KEYFRAME_COUNT;
        cfg_data <= CFG_DAT_W'(count);
        @(posedge clk);
        cfg_idx  <= CFG_FAN_OVERRIDE;
        cfg_data <= CFG_DAT_W'(override);
        @(posedge clk);
        cfg_we   <= 1'b0;
        active_keyframes = (count > TABLE_SIZE) ? TABLE_SIZE : count;
    endtask

    // Reload all entries; the valid ones ascend unless the table is scrambled.
    task automatic load_table(input bit ordered);
        int unsigned times [$];
        int unsigned t;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (ordered && i > 0 && $urandom_range(0, 7) == 0) t = times[i-1];
            else if ($urandom_range(0, 15) == 0) t = ($urandom_range(0, 1)) ? 0 : 86399;
            else if (!ordered && $urandom_range(0, 7) == 0) t = $urandom_range(86400, 131071);
            else t = $urandom_range(0, DAY_SECONDS - 1);
            times.push_back(t);
        end
        if (ordered) times.sort();
        for (int i = 0; i < TABLE_SIZE; i++) begin
            send_load(INDEX_W'(i), TIME_W'(times[i]), rand_level(), rand_level(),
                      rand_level());
        end
    endtask

    // Result side: either ready waits for the word, or the word waits for ready.
    initial begin : result_sink
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (no_idle || $urandom_range(0, 1) == 1) begin
                out_ch.ready <= 1'b1;
                do @(posedge clk); while (!out_ch.valid);
            end else begin
                out_ch.ready <= 1'b0;
                do @(posedge clk); while (!out_ch.valid);
                repeat (draw_gap()) @(posedge clk);
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        int unsigned count;
        bit          override;
        in_ch.valid         <= 1'b0;
        in_ch.action        <= ACT_LOAD;
        in_ch.entry_index   <= '0;
        in_ch.entry_time    <= '0;
        in_ch.entry_blue    <= '0;
        in_ch.entry_white   <= '0;
        in_ch.entry_uv      <= '0;
        in_ch.second_of_day <= '0;
        in_ch.accl_scale    <= '0;
        cfg_we              <= 1'b0;
        cfg_idx             <= CFG_KEYFRAME_COUNT;
        cfg_data            <= '0;
        rst_n               <= 1'b0;
        no_idle             = 1'b0;
        active_keyframes    = 0;
        for (int i = 0; i < TABLE_SIZE; i++) loaded_time[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: all levels zero, including a saturated scale.
        apply_settings(0, 1'b0);
        send_eval('0, '0);
        send_eval(TIME_W'(DAY_SECONDS - 1), SCALE_W'(131071));

        // Full table with extreme levels and two keyframes at the same time.
        for (int i = 0; i < TABLE_SIZE; i++) begin
            send_load(INDEX_W'(i), TIME_W'(((i == 5) ? 4 : i) * 5400),
                      (i == 0) ? LVL_W'(10000) : LVL_W'((i * 1300) % 10001),
                      (i == 0) ? LVL_W'(0) : LVL_W'(10000 - i * 600),
                      (i == 0) ? LVL_W'(16383) : LVL_W'((i * 4111) % 10001));
        end

        // One keyframe: entry zero is held.
        apply_settings(1, 1'b0);
        send_eval(TIME_W'(40000), SCALE_W'(Q16_ONE));

        // Sixteen keyframes with fan override.
        apply_settings(16, 1'b1);
        send_eval(TIME_W'(4 * 5400), SCALE_W'(Q16_ONE));
        send_eval(TIME_W'(30000), SCALE_W'(ROUND_HALF));
        send_eval(TIME_W'(DAY_SECONDS - 1), SCALE_W'(Q16_ONE));
        send_eval('0, SCALE_W'(Q16_ONE));
        send_eval(TIME_W'(131071), SCALE_W'(Q16_ONE));

        // Random phases under a spread of settings, extremes first.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin count = 2;  override = 1'b0; end
                1: begin count = 16; override = 1'b0; end
                2: begin count = 31; override = 1'b1; end
                3: begin count = 1;  override = 1'b1; end
                4: begin count = 0;  override = 1'b0; end
                5: begin count = 17; override = 1'b0; end
                default: begin
                    count    = $urandom_range(0, 31);
                    override = $urandom_range(0, 1);
                end
            endcase
            apply_settings(count, override);
            no_idle = ($urandom_range(0, 3) == 0);
            load_table($urandom_range(0, 5) != 0);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_load(INDEX_W'($urandom), TIME_W'($urandom), rand_level(),
                              rand_level(), rand_level());
                end else begin
                    send_eval(pick_second(), rand_scale());
                end
            end
        end

        settle();
        if (fail_count == 0 && pending_lights == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/kfli_pkg.sv
hdl/kfli_in_if.sv
hdl/kfli_out_if.sv
hdl/kfli_ram.sv
hdl/kfli_lane.sv
hdl/daily_keyframe_light_interpolator_core.sv
test/daily_keyframe_light_interpolator_core_checker.sv
test/daily_keyframe_light_interpolator_core_test.sv
